// ===== rtl/source_tokenizer_core_macros.svh =====
// Assertion macros shared by the tokenizer modules.
// No dependencies; included inside module bodies.
`ifndef SOURCE_TOKENIZER_CORE_MACROS_SVH
`define SOURCE_TOKENIZER_CORE_MACROS_SVH

// same-cycle implication
`define STOK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stok assertion failed");

// next-cycle implication
`define STOK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stok assertion failed");

`endif

// ===== rtl/stok_pkg.sv =====
// Types, codes and byte-class functions of the source tokenizer.
// No dependencies.
`timescale 1ns / 1ps

package stok_pkg;

	localparam int BYTE_W   = 8;
	localparam int KIND_W   = 4;
	localparam int OFFSET_W = 32;
	localparam int LENGTH_W = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
	localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
	localparam logic [BYTE_W-1:0] CH_BAR   = 8'h7C;
	localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
	localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
	localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;

	typedef enum logic [KIND_W-1:0] {
		KIND_CHAR  = 4'd0,
		KIND_AND   = 4'd1,
		KIND_EQ    = 4'd2,
		KIND_GE    = 4'd3,
		KIND_IDENT = 4'd4,
		KIND_LE    = 4'd5,
		KIND_NE    = 4'd6,
		KIND_OR    = 4'd7,
		KIND_END   = 4'd8
	} token_kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_HELD    = 2'd1,
		MODE_IDENT   = 2'd2,
		MODE_COMMENT = 2'd3
	} lex_mode_t;

	typedef struct packed {
		token_kind_t         kind;
		logic [BYTE_W-1:0]   char_code;
		logic [OFFSET_W-1:0] start_offset;
		logic [LENGTH_W-1:0] ident_length;
		logic                last_of_run;
	} token_t;

	typedef struct packed {
		logic   vld0;
		logic   vld1;
		token_t tok0;
		token_t tok1;
	} push_t;

	function automatic logic is_blank(input logic [BYTE_W-1:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
	endfunction

	function automatic logic is_alpha(input logic [BYTE_W-1:0] b);
		return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
			(b == CH_UNDER);
	endfunction

	function automatic logic is_ident_char(input logic [BYTE_W-1:0] b);
		return is_alpha(b) || ((b >= 8'h30) && (b <= 8'h39));
	endfunction

	function automatic logic is_op_start(input logic [BYTE_W-1:0] b);
		return (b == CH_BANG) || (b == CH_AMP) || (b == CH_SLASH) || (b == CH_LT) ||
			(b == CH_EQ) || (b == CH_GT) || (b == CH_BAR);
	endfunction

	// KIND_CHAR when the pair is not a two-character operator
	function automatic token_kind_t pair_kind(input logic [BYTE_W-1:0] p,
		input logic [BYTE_W-1:0] b);
		token_kind_t k;
		k = KIND_CHAR;
		if ((p == CH_BANG) && (b == CH_EQ)) k = KIND_NE;
		else if ((p == CH_AMP) && (b == CH_AMP)) k = KIND_AND;
		else if ((p == CH_LT) && (b == CH_EQ)) k = KIND_LE;
		else if ((p == CH_EQ) && (b == CH_EQ)) k = KIND_EQ;
		else if ((p == CH_GT) && (b == CH_EQ)) k = KIND_GE;
		else if ((p == CH_BAR) && (b == CH_BAR)) k = KIND_OR;
		return k;
	endfunction

endpackage

// ===== rtl/stok_ifs.sv =====
// Valid/ready channel interfaces: source bytes in, tokens out.
// Depends on stok_pkg.
`timescale 1ns / 1ps

interface stok_byte_if;
	import stok_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

interface stok_token_if;
	import stok_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   token_kind;
	logic [BYTE_W-1:0]   char_code;
	logic [OFFSET_W-1:0] start_offset;
	logic [LENGTH_W-1:0] ident_length;
	logic                last_of_run;

	modport source (output valid, output token_kind, output char_code, output start_offset,
		output ident_length, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input char_code, input start_offset,
		input ident_length, input last_of_run, output ready);
endinterface

// ===== rtl/source_tokenizer_core.sv =====
// Source tokenizer top level: input byte register, lexer, token queue.
// Depends on stok_pkg, stok_ifs, stok_lexer and stok_queue.
//
//   channel    | dir | payload
//   byte_in    | in  | text_byte
//   token_out  | out | token_kind, char_code, start_offset, ident_length, last_of_run
//
// One byte is accepted per cycle unless stalled; it is decoded once registered.
// A byte yields zero, one or two tokens; the output port hands out one token a cycle
// while the sink is ready, so bytes giving two tokens each are paced by the output.
// A registered byte moves on when the four-entry token queue has two free slots.
// arst_n clears the lexer mode, offsets, identifier length and the queue.
`timescale 1ns / 1ps

module source_tokenizer_core #(
	parameter int OFFSET_BITS = 32,
	parameter int LENGTH_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	stok_byte_if.sink     byte_in,
	stok_token_if.source  token_out
);
	import stok_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              room2;
	logic              advance;
	push_t             push;

	assign advance       = valid_s1 && room2;
	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			byte_s1 <= byte_in.text_byte;
		end
	end

	stok_lexer #(
		.OFFSET_BITS(OFFSET_BITS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.text_byte (byte_s1),
		.push      (push)
	);

	stok_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.token_out (token_out)
	);

endmodule

// ===== rtl/stok_lexer.sv =====
// Lexer state and token decode: one byte in, up to two tokens pushed.
// Depends on stok_pkg and source_tokenizer_core_macros.svh.
`timescale 1ns / 1ps

module stok_lexer #(
	parameter int OFFSET_BITS = 32,
	parameter int LENGTH_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [stok_pkg::BYTE_W-1:0] text_byte,
	output stok_pkg::push_t             push
);
	import stok_pkg::*;
	`include "source_tokenizer_core_macros.svh"

	localparam logic [OFFSET_BITS-1:0] POS_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
	localparam logic [LENGTH_BITS-1:0] LEN_ONE = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

	lex_mode_t                mode_q, mode_d;
	logic [BYTE_W-1:0]        pend_char_q;
	logic [OFFSET_BITS-1:0]   pend_off_q;
	logic [LENGTH_BITS-1:0]   cnt_q;
	logic [OFFSET_BITS-1:0]   pos_q;

	logic [OFFSET_BITS+OFFSET_W-1:0] pos_ext, poff_ext;
	logic [LENGTH_BITS+LENGTH_W-1:0] cnt_ext;
	logic [OFFSET_W-1:0]             pos_o, poff_o;
	logic [LENGTH_W-1:0]             cnt_o;

	logic        idle_emit, idle_hold, idle_ident;
	lex_mode_t   idle_mode;
	token_t      idle_tok;
	logic        flush_vld, run_idle, cnt_inc, two;
	token_t      flush_tok;
	token_kind_t pk;

	assign pos_ext  = {{OFFSET_W{1'b0}}, pos_q};
	assign poff_ext = {{OFFSET_W{1'b0}}, pend_off_q};
	assign cnt_ext  = {{LENGTH_W{1'b0}}, cnt_q};
	assign pos_o    = pos_ext[OFFSET_W-1:0];
	assign poff_o   = poff_ext[OFFSET_W-1:0];
	assign cnt_o    = cnt_ext[LENGTH_W-1:0];
	assign pk       = pair_kind(pend_char_q, text_byte);

	// byte taken with nothing held
	always_comb begin
		idle_emit  = 1'b0;
		idle_hold  = 1'b0;
		idle_ident = 1'b0;
		idle_mode  = MODE_IDLE;
		idle_tok   = '{kind: KIND_CHAR, char_code: text_byte, start_offset: pos_o,
			ident_length: '0, last_of_run: 1'b1};
		if (is_blank(text_byte)) begin
			idle_mode = MODE_IDLE;
		end else if (text_byte == CH_HASH) begin
			idle_mode = MODE_COMMENT;
		end else if (is_op_start(text_byte)) begin
			idle_mode = MODE_HELD;
			idle_hold = 1'b1;
		end else if (is_alpha(text_byte)) begin
			idle_mode  = MODE_IDENT;
			idle_ident = 1'b1;
		end else if (text_byte == CH_NUL) begin
			idle_emit          = 1'b1;
			idle_tok.kind      = KIND_END;
			idle_tok.char_code = '0;
		end else begin
			idle_emit = 1'b1;
		end
	end

	always_comb begin
		flush_vld = 1'b0;
		run_idle  = 1'b0;
		cnt_inc   = 1'b0;
		mode_d    = mode_q;
		flush_tok = '{kind: KIND_CHAR, char_code: '0, start_offset: poff_o,
			ident_length: '0, last_of_run: 1'b1};
		case (mode_q)
			MODE_COMMENT: begin
				if (text_byte == CH_LF) begin
					mode_d = MODE_IDLE;
				end else if (text_byte == CH_NUL) begin
					mode_d                 = MODE_IDLE;
					flush_vld              = 1'b1;
					flush_tok.kind         = KIND_END;
					flush_tok.start_offset = pos_o;
				end
			end
			MODE_HELD: begin
				mode_d = MODE_IDLE;
				if ((pend_char_q == CH_SLASH) && (text_byte == CH_SLASH)) begin
					mode_d = MODE_COMMENT;
				end else if (pk != KIND_CHAR) begin
					flush_vld      = 1'b1;
					flush_tok.kind = pk;
				end else begin
					flush_vld           = 1'b1;
					flush_tok.char_code = pend_char_q;
					run_idle            = 1'b1;
				end
			end
			MODE_IDENT: begin
				if (is_ident_char(text_byte)) begin
					cnt_inc = 1'b1;
				end else begin
					flush_vld              = 1'b1;
					flush_tok.kind         = KIND_IDENT;
					flush_tok.ident_length = cnt_o;
					run_idle               = 1'b1;
				end
			end
			default: begin
				run_idle = 1'b1;
			end
		endcase
		if (run_idle) begin
			mode_d = idle_mode;
		end
	end

	always_comb begin
		two                    = flush_vld && run_idle && idle_emit;
		push.vld0              = advance && (flush_vld || (run_idle && idle_emit));
		push.vld1              = advance && two;
		push.tok0              = flush_vld ? flush_tok : idle_tok;
		push.tok0.last_of_run  = !two;
		push.tok1              = idle_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			pend_char_q <= '0;
			pend_off_q  <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			pos_q  <= pos_q + POS_ONE;
			if (run_idle && idle_hold) begin
				pend_char_q <= text_byte;
				pend_off_q  <= pos_q;
			end
			if (run_idle && idle_ident) begin
				pend_off_q <= pos_q;
				cnt_q      <= LEN_ONE;
			end else if (cnt_inc && (cnt_q != {LENGTH_BITS{1'b1}})) begin
				cnt_q <= cnt_q + LEN_ONE;
			end
		end
	end

	`STOK_ASSERT_NOW(a_ident_len, clk, arst_n, mode_q == MODE_IDENT, cnt_q != '0)
	`STOK_ASSERT_NOW(a_second_needs_first, clk, arst_n, push.vld1, push.vld0 && flush_vld)
	`STOK_ASSERT_NEXT(a_pos_step, clk, arst_n, advance, pos_q == $past(pos_q) + POS_ONE)

endmodule

// ===== rtl/stok_queue.sv =====
// Token queue: takes up to two tokens a cycle, hands out one while the sink is ready.
// Depends on stok_pkg, stok_ifs and source_tokenizer_core_macros.svh.
`timescale 1ns / 1ps

module stok_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  stok_pkg::push_t push,
	output logic            room2,
	stok_token_if.source    token_out
);
	import stok_pkg::*;
	`include "source_tokenizer_core_macros.svh"

	token_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic [1:0]          n_push;
	logic                pop;
	token_t              head;

	assign n_push = {1'b0, push.vld0} + {1'b0, push.vld1};
	assign pop    = token_out.valid && token_out.ready;
	assign room2  = cnt_q <= QCNT_W'(QUEUE_DEPTH - 2);
	assign head   = mem_q[rd_ptr_q];

	assign token_out.valid        = cnt_q != '0;
	assign token_out.token_kind   = head.kind;
	assign token_out.char_code    = head.char_code;
	assign token_out.start_offset = head.start_offset;
	assign token_out.ident_length = head.ident_length;
	assign token_out.last_of_run  = head.last_of_run;

	always_ff @(posedge clk) begin
		if (push.vld0) begin
			mem_q[wr_ptr_q] <= push.tok0;
		end
		if (push.vld1) begin
			mem_q[wr_ptr_q + QPTR_W'(1)] <= push.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			cnt_q    <= cnt_q + QCNT_W'(n_push) - QCNT_W'(pop);
		end
	end

	`STOK_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= QCNT_W'(QUEUE_DEPTH))
	`STOK_ASSERT_NOW(a_push_room, clk, arst_n, push.vld0, room2)
	`STOK_ASSERT_NEXT(a_cnt_track, clk, arst_n, 1'b1,
		cnt_q == $past(cnt_q) + QCNT_W'($past(n_push)) - QCNT_W'($past(pop)))

endmodule

// ===== verif/source_tokenizer_core_checker.sv =====
// Token checker: watches the byte and token channels of the source tokenizer,
// predicts the token stream and compares it field by field.
// Depends on stok_pkg and stok_ifs.
`timescale 1ns / 1ps

module source_tokenizer_core_checker (
	input  logic  clk,
	input  logic  arst_n,
	stok_byte_if  byte_mon,
	stok_token_if token_mon,
	output int    fail_count,
	output int    outstanding
);
	import stok_pkg::*;

	lex_mode_t           mode;
	logic [BYTE_W-1:0]   held_char;
	logic [OFFSET_W-1:0] held_offset;
	logic [LENGTH_W-1:0] word_length;
	logic [OFFSET_W-1:0] position;
	token_t              step_tokens[$];
	token_t              expected_tokens[$];
	int                  tokens_seen;

	function automatic logic blank_byte(input logic [BYTE_W-1:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
	endfunction

	function automatic logic word_lead(input logic [BYTE_W-1:0] b);
		return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) ||
			(b == CH_UNDER);
	endfunction

	function automatic logic word_byte(input logic [BYTE_W-1:0] b);
		return word_lead(b) || ((b >= 8'h30) && (b <= 8'h39));
	endfunction

	function automatic logic op_lead(input logic [BYTE_W-1:0] b);
		return (b == CH_BANG) || (b == CH_AMP) || (b == CH_SLASH) || (b == CH_LT) ||
			(b == CH_EQ) || (b == CH_GT) || (b == CH_BAR);
	endfunction

	// KIND_CHAR when the two bytes do not form an operator
	function automatic token_kind_t operator_kind(input logic [BYTE_W-1:0] lead,
		input logic [BYTE_W-1:0] follow);
		token_kind_t k;
		k = KIND_CHAR;
		if (follow == CH_EQ) begin
			case (lead)
				CH_BANG: k = KIND_NE;
				CH_LT:   k = KIND_LE;
				CH_EQ:   k = KIND_EQ;
				CH_GT:   k = KIND_GE;
				default: k = KIND_CHAR;
			endcase
		end else if ((follow == lead) && (lead == CH_AMP)) begin
			k = KIND_AND;
		end else if ((follow == lead) && (lead == CH_BAR)) begin
			k = KIND_OR;
		end
		return k;
	endfunction

	task automatic emit(input token_kind_t kind, input logic [BYTE_W-1:0] code,
		input logic [OFFSET_W-1:0] offset, input logic [LENGTH_W-1:0] length);
		token_t t;
		t.kind = kind;
		t.char_code = code;
		t.start_offset = offset;
		t.ident_length = length;
		t.last_of_run = 1'b0;
		step_tokens.push_back(t);
	endtask

	// byte seen with nothing held
	task automatic take_fresh(input logic [BYTE_W-1:0] b);
		if (blank_byte(b)) begin
			mode = MODE_IDLE;
		end else if (b == CH_HASH) begin
			mode = MODE_COMMENT;
		end else if (op_lead(b)) begin
			mode = MODE_HELD;
			held_char = b;
			held_offset = position;
		end else if (word_lead(b)) begin
			mode = MODE_IDENT;
			held_offset = position;
			word_length = LENGTH_W'(1);
		end else if (b == CH_NUL) begin
			emit(KIND_END, '0, position, '0);
		end else begin
			emit(KIND_CHAR, b, position, '0);
		end
	endtask

	task automatic lex_byte(input logic [BYTE_W-1:0] b);
		token_kind_t k;
		step_tokens.delete();
		case (mode)
			MODE_COMMENT: begin
				if (b == CH_LF) begin
					mode = MODE_IDLE;
				end else if (b == CH_NUL) begin
					mode = MODE_IDLE;
					emit(KIND_END, '0, position, '0);
				end
			end
			MODE_HELD: begin
				k = operator_kind(held_char, b);
				mode = MODE_IDLE;
				if ((held_char == CH_SLASH) && (b == CH_SLASH)) begin
					mode = MODE_COMMENT;
				end else if (k != KIND_CHAR) begin
					emit(k, '0, held_offset, '0);
				end else begin
					emit(KIND_CHAR, held_char, held_offset, '0);
					take_fresh(b);
				end
			end
			MODE_IDENT: begin
				if (word_byte(b)) begin
					if (word_length != '1)
						word_length = word_length + 1'b1;
				end else begin
					mode = MODE_IDLE;
					emit(KIND_IDENT, '0, held_offset, word_length);
					take_fresh(b);
				end
			end
			default: take_fresh(b);
		endcase
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
		foreach (step_tokens[i])
			expected_tokens.push_back(step_tokens[i]);
		position = position + 1'b1;
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		$display("token %0d: %s is %0h, expected %0h", tokens_seen, field, got, want);
		fail_count++;
	endtask

	task automatic check_token();
		token_t want;
		if (expected_tokens.size() == 0) begin
			report_mismatch("token_kind with no token expected", token_mon.token_kind, '0);
		end else begin
			want = expected_tokens.pop_front();
			if (token_mon.token_kind !== want.kind)
				report_mismatch("token_kind", token_mon.token_kind, want.kind);
			if (token_mon.char_code !== want.char_code)
				report_mismatch("char_code", token_mon.char_code, want.char_code);
			if (token_mon.start_offset !== want.start_offset)
				report_mismatch("start_offset", token_mon.start_offset, want.start_offset);
			if (token_mon.ident_length !== want.ident_length)
				report_mismatch("ident_length", token_mon.ident_length, want.ident_length);
			if (token_mon.last_of_run !== want.last_of_run)
				report_mismatch("last_of_run", token_mon.last_of_run, want.last_of_run);
		end
		tokens_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = MODE_IDLE;
			held_char = '0;
			held_offset = '0;
			word_length = '0;
			position = '0;
			expected_tokens.delete();
			outstanding = 0;
			fail_count = 0;
			tokens_seen = 0;
		end else begin
			if (token_mon.valid && token_mon.ready)
				check_token();
			if (byte_mon.valid && byte_mon.ready)
				lex_byte(byte_mon.text_byte);
			outstanding = expected_tokens.size();
		end
	end

endmodule

// ===== verif/source_tokenizer_core_test.sv =====
// Testbench top of the source tokenizer: clock, reset, byte stimulus, token
// back-pressure, watchdog and verdict. Depends on stok_pkg, stok_ifs,
// source_tokenizer_core and source_tokenizer_core_checker.
`timescale 1ns / 1ps

module source_tokenizer_core_test;
	import stok_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   items_sent;
	bit   stall_request;
	int   fail_count;
	int   outstanding;

	stok_byte_if  byte_ch ();
	stok_token_if token_ch ();

	source_tokenizer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_ch),
		.token_out (token_ch)
	);

	source_tokenizer_core_checker token_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_mon    (byte_ch),
		.token_mon   (token_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.text_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		items_sent++;
	endtask

	function automatic logic [BYTE_W-1:0] pick_letter();
		case ($urandom_range(2))
			0: return BYTE_W'(8'h61 + $urandom_range(25));
			1: return BYTE_W'(8'h41 + $urandom_range(25));
			default: return CH_UNDER;
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_word_byte();
		if ($urandom_range(3) == 0)
			return BYTE_W'(8'h30 + $urandom_range(9));
		return pick_letter();
	endfunction

	function automatic logic [BYTE_W-1:0] pick_op_lead();
		case ($urandom_range(6))
			0: return CH_BANG;
			1: return CH_AMP;
			2: return CH_SLASH;
			3: return CH_LT;
			4: return CH_EQ;
			5: return CH_GT;
			default: return CH_BAR;
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_blank();
		case ($urandom_range(3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// one lexically meaningful fragment with random content, or noise
	task automatic send_fragment();
		logic [BYTE_W-1:0] lead;
		logic [BYTE_W-1:0] body;
		int                n;
		case ($urandom_range(9))
			0, 1: begin
				send_byte(pick_letter());
				n = $urandom_range(11);
				repeat (n) send_byte(pick_word_byte());
			end
			2: begin
				lead = pick_op_lead();
				send_byte(lead);
				if ((lead == CH_AMP) || (lead == CH_BAR) || (lead == CH_SLASH))
					send_byte(lead);
				else
					send_byte(CH_EQ);
			end
			3: begin
				send_byte(pick_op_lead());
				send_byte(BYTE_W'($urandom_range(255)));
			end
			4: begin
				n = $urandom_range(1, 3);
				repeat (n) send_byte(pick_blank());
			end
			5: begin
				if ($urandom_range(1) == 0) begin
					send_byte(CH_HASH);
				end else begin
					send_byte(CH_SLASH);
					send_byte(CH_SLASH);
				end
				n = $urandom_range(8);
				repeat (n) begin
					body = BYTE_W'($urandom_range(1, 255));
					send_byte((body == CH_LF) ? CH_SPACE : body);
				end
				send_byte(($urandom_range(7) == 0) ? CH_NUL : CH_LF);
			end
			6: begin
				n = $urandom_range(1, 4);
				repeat (n) send_byte(BYTE_W'(8'h30 + $urandom_range(9)));
			end
			7: send_byte(BYTE_W'($urandom_range(255)));
			8: send_byte(CH_NUL);
			default: send_byte(BYTE_W'($urandom_range(128, 255)));
		endcase
	endtask

	// stimulus and verdict
	initial begin
		string lead_text;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.text_byte = '0;
		send_idle_pct = 21;
		recv_idle_pct = 47;
		items_sent = 0;
		stall_request = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every operator, held char not completed, both comment forms
		lead_text = "_a9&&||==!=<=>=<a//c\n#z";
		for (int i = 0; i < lead_text.len(); i++)
			send_byte(lead_text[i]);
		send_byte(CH_NUL);
		send_byte("q");
		send_byte(CH_EQ);
		send_byte(CH_NUL);
		send_byte("x");
		send_byte(CH_NUL);
		send_byte(8'h80);
		send_byte(8'hFF);

		while (items_sent < 370) send_fragment();
		send_idle_pct = 47;
		recv_idle_pct = 21;
		while (items_sent < 710) send_fragment();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 1'b1;
		while (items_sent < 1050) send_fragment();
		send_byte(CH_NUL);

		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if ((fail_count == 0) && (outstanding == 0))
			$display("** source_tokenizer_core: PASSED **");
		else
			$display("** source_tokenizer_core: FAILED **");
		$finish;
	end

	// token back-pressure, with one long hold-off
	initial begin
		int hold_left;
		bit held_once;
		hold_left = 0;
		held_once = 1'b0;
		token_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request && !held_once) begin
				hold_left = HOLD_CYCLES;
				held_once = 1'b1;
			end
			if (hold_left > 0) begin
				token_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				token_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no item moving
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (token_ch.valid && token_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** source_tokenizer_core: FAILED **");
		$finish;
	end

endmodule

// ===== source_tokenizer_core.f =====
+incdir+rtl
rtl/stok_pkg.sv
rtl/stok_ifs.sv
rtl/stok_lexer.sv
rtl/stok_queue.sv
rtl/source_tokenizer_core.sv
verif/source_tokenizer_core_checker.sv
verif/source_tokenizer_core_test.sv
